/* rtl/core/eslt_pkg.sv */
// Shared types and codes for the edge set list table.
// No dependencies; imported by eslt_ctrl and edge_set_list_table_unit.
package eslt_pkg;

  localparam int NODE_W  = 8;
  localparam int KEY_W   = 2 * NODE_W;
  localparam int CNT_O_W = 5;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOMATCH = 2'd2
  } status_t;

  // One result item, handed from the sequencer to the output stage.
  typedef struct packed {
    status_t              status;
    logic [CNT_O_W-1:0]   entry_count;
    logic                 found;
  } res_t;

endpackage

/* rtl/core/edge_set_list_table_unit.sv */
// Top level of the edge set list table: stream ports, output register,
// entry RAM and sequencer. Depends on eslt_pkg, eslt_ram, eslt_ctrl.
//
// Usage:
//   Each input transfer carries one operation (add, remove, query, clear) on
//   an edge given as a pair of 8-bit node ids. Each produces exactly one
//   output transfer with found, entry_count and status.
//   Entries sit in a RAM of CAPACITY words, one per cycle through a single
//   key comparator under a small sequencer.
// Flow per operation (input transfer to result in the output register):
//   add, clear          : straight to the result, no RAM scan
//   query               : scan of the list (stops at the first hit)
//   remove              : search, then shift of the tail
//   The scan length is set by the one-read-per-cycle RAM port.
//   in_tready is high only while the sequencer is idle; one operation at a
//   time is in flight. The sequencer is idle again in the cycle after the
//   result loads, so even add and clear never overlap the next operation.
// Reset: rst_n (synchronous, active low) empties the list; RAM contents are
//   left as they are and never read before written.
// Stall: a result waits in the output register; the sequencer holds its
//   finished result until that register frees, so nothing is dropped.
module edge_set_list_table_unit
  import eslt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input: [1:0] func, [9:2] first_node, [17:10] second_node, [23:18] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // output: [0] found, [5:1] entry_count, [7:6] status
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata
);

  localparam int AW = $clog2(CAPACITY);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;
  logic [KEY_W-1:0] op_key;
  func_t            op_func;

  logic             out_valid_r;
  logic [7:0]       out_data_r;

  // key layout: first node in the high byte
  assign op_func = func_t'(in_tdata[1:0]);
  assign op_key  = {in_tdata[9:2], in_tdata[17:10]};

  eslt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  eslt_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (in_tvalid),
    .op_ready  (in_tready),
    .op_func   (op_func),
    .op_key    (op_key),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // output register: loads when empty or when its transfer completes
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= {res.status, res.entry_count, res.found};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second operation taken while busy");

  a_result_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_valid_r && !out_tready) |=> res_valid)
    else $error("result lost while output stalled");

endmodule

/* rtl/core/eslt_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module eslt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

/* rtl/core/eslt_ctrl.sv */
// Sequencer for the edge list: walks the RAM one entry per cycle for search
// (through a single key comparator) and for shift-down. Depends on eslt_pkg.
module eslt_ctrl
  import eslt_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst_n,
  // operation in
  input  logic             op_valid,
  output logic             op_ready,
  input  func_t            op_func,
  input  logic [KEY_W-1:0] op_key,
  // result out
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  // entry RAM
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [KEY_W-1:0] wr_data,
  output logic [AW-1:0]    rd_addr,
  input  logic [KEY_W-1:0] rd_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pend_idx_r, pend_idx_nxt;
  func_t            func_r, func_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             found_r, found_nxt;
  status_t          status_r, status_nxt;

  logic             issue;
  logic             hit;
  logic [CW+CNT_O_W-1:0] cnt_ext;

  assign issue   = (ptr_r < count_r);
  assign hit     = pend_r && (rd_data == key_r);
  assign rd_addr = ptr_r[AW-1:0];
  assign cnt_ext = {{CNT_O_W{1'b0}}, count_r};

  assign op_ready        = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_FINISH);
  assign res.found       = found_r;
  assign res.entry_count = cnt_ext[CNT_O_W-1:0];
  assign res.status      = status_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    func_nxt     = func_r;
    key_nxt      = key_r;
    found_nxt    = found_r;
    status_nxt   = status_r;
    wr_en        = 1'b0;
    wr_addr      = count_r[AW-1:0];
    wr_data      = op_key;

    unique case (state_r)
      S_IDLE: begin
        if (op_valid) begin
          func_nxt   = op_func;
          key_nxt    = op_key;
          found_nxt  = 1'b0;
          status_nxt = STAT_OK;
          ptr_nxt    = '0;
          pend_nxt   = 1'b0;
          unique case (op_func)
            FUNC_ADD: begin
              if (count_r >= CAP) begin
                status_nxt = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
              state_nxt = S_FINISH;
            end
            FUNC_REMOVE, FUNC_QUERY: begin
              state_nxt = S_SCAN;
            end
            default: begin
              count_nxt = '0;
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        // read pipeline keeps running: address ptr_r out, entry pend_idx_r back
        pend_nxt     = issue;
        pend_idx_nxt = ptr_r[AW-1:0];
        ptr_nxt      = ptr_r + CW'(issue);
        if (hit) begin
          found_nxt = 1'b1;
          state_nxt = (func_r == FUNC_QUERY) ? S_FINISH : S_SHIFT;
        end else if (!issue && !pend_r) begin
          status_nxt = (func_r == FUNC_REMOVE) ? STAT_NOMATCH : STAT_OK;
          state_nxt  = S_FINISH;
        end
      end
      S_SHIFT: begin
        // entry k comes back, lands in slot k-1
        pend_nxt     = issue;
        pend_idx_nxt = ptr_r[AW-1:0];
        ptr_nxt      = ptr_r + CW'(issue);
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx_r - 1'b1;
          wr_data = rd_data;
        end
        if (!issue && !pend_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("entry count above capacity");

  a_scan_no_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> $stable(count_r))
    else $error("count changed during search");

  a_write_when_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SHIFT || state_r == S_IDLE))
    else $error("RAM write outside add or shift");

  a_found_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && found_r) |-> (status_r == STAT_OK))
    else $error("found result with error status");

  a_shift_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit && func_r == FUNC_REMOVE) |=> (state_r == S_SHIFT))
    else $error("remove hit did not start shift");

endmodule
